@@ sv/smnr_pkg.sv @@
// ============================================================================
// smnr_pkg
// Shared types, constants and helpers for the shell-model nonlinear
// right-hand side block.
// ============================================================================
package smnr_pkg;

    localparam int DATA_W        = 32;
    localparam int IDX_W         = 6;
    localparam int SEEN_W        = 7;
    localparam int PROD_W        = 64;
    localparam int SAT_W         = 66;
    localparam int ACC_W         = 34;
    localparam int MAX_SHELLS    = 64;
    localparam int VEL_FRAC_BITS = 16;
    localparam int K_FRAC_BITS   = 8;

    // Configuration register indexes.
    localparam logic [1:0] REG_COEF_A2       = 2'd0;
    localparam logic [1:0] REG_COEF_A3       = 2'd1;
    localparam logic [1:0] REG_ROTATION_RATE = 2'd2;

    localparam logic signed [DATA_W-1:0] COEF_A2_RST       = -32'sd98304;
    localparam logic signed [DATA_W-1:0] COEF_A3_RST       = 32'sd32768;
    localparam logic signed [DATA_W-1:0] ROTATION_RATE_RST = 32'sd0;

    // Which term of the right-hand side the shared unit is working on.
    typedef enum logic [1:0] {
        TERM_T1  = 2'd0,
        TERM_T2  = 2'd1,
        TERM_T3  = 2'd2,
        TERM_COR = 2'd3
    } term_t;

    // Multiply steps within one term. The Coriolis term uses only the first
    // two: rate times imaginary part, then rate times real part.
    typedef enum logic [2:0] {
        STEP_RR  = 3'd0,
        STEP_II  = 3'd1,
        STEP_RI  = 3'd2,
        STEP_IR  = 3'd3,
        STEP_KRE = 3'd4,
        STEP_KIM = 3'd5,
        STEP_SRE = 3'd6,
        STEP_SIM = 3'd7
    } step_t;

    typedef struct packed {
        logic  valid;
        term_t term;
        step_t step;
    } uop_t;

    // Saturate a wide signed value to the 32-bit result range.
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = 66'sd2147483647;
        lo = -66'sd2147483648;
        if (v > hi) begin
            return hi[DATA_W-1:0];
        end else if (v < lo) begin
            return lo[DATA_W-1:0];
        end
        return v[DATA_W-1:0];
    endfunction

endpackage

@@ sv/smnr_datapath.sv @@
// ============================================================================
// smnr_datapath
// Shared multiply-add unit with the rounding, saturation and accumulation
// that follow it; one multiplication issues per cycle and finishes the next.
// ============================================================================
module smnr_datapath #(
    parameter int VEL_FRAC_BITS = smnr_pkg::VEL_FRAC_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  smnr_pkg::uop_t                       issue_op,
    input  logic                                 acc_clear,
    input  logic signed [smnr_pkg::DATA_W-1:0]   a_re,
    input  logic signed [smnr_pkg::DATA_W-1:0]   a_im,
    input  logic signed [smnr_pkg::DATA_W-1:0]   b_re,
    input  logic signed [smnr_pkg::DATA_W-1:0]   b_im,
    input  logic        [smnr_pkg::DATA_W-1:0]   kval,
    input  logic signed [smnr_pkg::DATA_W-1:0]   coef,
    input  logic signed [smnr_pkg::DATA_W-1:0]   omega,
    input  logic signed [smnr_pkg::DATA_W-1:0]   ctr_re,
    input  logic signed [smnr_pkg::DATA_W-1:0]   ctr_im,
    output logic signed [smnr_pkg::DATA_W-1:0]   res_re,
    output logic signed [smnr_pkg::DATA_W-1:0]   res_im
);

    localparam int DW = smnr_pkg::DATA_W;
    localparam int PW = smnr_pkg::PROD_W;
    localparam int SW = smnr_pkg::SAT_W;
    localparam int AW = smnr_pkg::ACC_W;
    localparam int KF = smnr_pkg::K_FRAC_BITS;
    localparam int QW = PW - VEL_FRAC_BITS;
    localparam int KW = PW - KF;
    localparam logic [PW-1:0] HALF_Q = PW'(1) << (VEL_FRAC_BITS - 1);
    localparam logic [PW-1:0] HALF_K = PW'(1) << (KF - 1);

    logic signed [DW:0]     opa;
    logic signed [DW:0]     opb;
    logic                   kshift;
    logic signed [2*DW+1:0] prod_full;
    logic        [PW-1:0]   prod_next;
    logic        [PW-1:0]   prod_reg;
    smnr_pkg::uop_t         fop_reg;

    logic signed [QW-1:0]   rq;
    logic signed [KW-1:0]   rk;
    logic signed [DW-1:0]   kprod;

    logic signed [QW-1:0]   x_reg, x_next;
    logic signed [DW-1:0]   c_re_reg, c_re_next;
    logic signed [DW-1:0]   c_im_reg, c_im_next;
    logic signed [DW-1:0]   r_re_reg, r_re_next;
    logic signed [DW-1:0]   r_im_reg, r_im_next;
    logic signed [AW-1:0]   nre_reg, nre_next;
    logic signed [AW-1:0]   nim_reg, nim_next;
    logic signed [DW-1:0]   res_re_reg, res_re_next;
    logic signed [DW-1:0]   res_im_reg, res_im_next;

    // Operand selection for the multiplication issued this cycle.
    always_comb begin
        opa    = (DW+1)'(a_re);
        opb    = (DW+1)'(b_re);
        kshift = 1'b0;
        case (issue_op.step)
            smnr_pkg::STEP_RR: begin
                if (issue_op.term == smnr_pkg::TERM_COR) begin
                    opa = (DW+1)'(omega);
                    opb = (DW+1)'(ctr_im);
                end else begin
                    opa = (DW+1)'(a_re);
                    opb = (DW+1)'(b_re);
                end
            end
            smnr_pkg::STEP_II: begin
                if (issue_op.term == smnr_pkg::TERM_COR) begin
                    opa = (DW+1)'(omega);
                    opb = (DW+1)'(ctr_re);
                end else begin
                    opa = (DW+1)'(a_im);
                    opb = (DW+1)'(b_im);
                end
            end
            smnr_pkg::STEP_RI: begin
                opa = (DW+1)'(a_re);
                opb = (DW+1)'(b_im);
            end
            smnr_pkg::STEP_IR: begin
                opa = (DW+1)'(a_im);
                opb = (DW+1)'(b_re);
            end
            smnr_pkg::STEP_KRE: begin
                opa    = (DW+1)'(c_re_reg);
                opb    = $signed({1'b0, kval});
                kshift = 1'b1;
            end
            smnr_pkg::STEP_KIM: begin
                opa    = (DW+1)'(c_im_reg);
                opb    = $signed({1'b0, kval});
                kshift = 1'b1;
            end
            smnr_pkg::STEP_SRE: begin
                opa = (DW+1)'(coef);
                opb = (DW+1)'(r_re_reg);
            end
            smnr_pkg::STEP_SIM: begin
                opa = (DW+1)'(coef);
                opb = (DW+1)'(r_im_reg);
            end
            default: begin
                opa = (DW+1)'(a_re);
                opb = (DW+1)'(b_re);
            end
        endcase
    end

    // The rounding half is added with the product; every product fits in
    // 64 signed bits, so the upper bits of the full product are dropped.
    assign prod_full = opa * opb;
    assign prod_next = prod_full[PW-1:0] + (kshift ? HALF_K : HALF_Q);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fop_reg <= '0;
        end else begin
            fop_reg <= issue_op;
        end
        if (issue_op.valid) begin
            prod_reg <= prod_next;
        end
    end

    assign rq    = prod_reg[PW-1:VEL_FRAC_BITS];
    assign rk    = prod_reg[PW-1:KF];
    assign kprod = smnr_pkg::sat32(SW'(rk));

    // Finish of the multiplication issued in the previous cycle.
    always_comb begin
        x_next      = x_reg;
        c_re_next   = c_re_reg;
        c_im_next   = c_im_reg;
        r_re_next   = r_re_reg;
        r_im_next   = r_im_reg;
        nre_next    = nre_reg;
        nim_next    = nim_reg;
        res_re_next = res_re_reg;
        res_im_next = res_im_reg;
        if (fop_reg.valid) begin
            case (fop_reg.step)
                smnr_pkg::STEP_RR: begin
                    if (fop_reg.term == smnr_pkg::TERM_COR) begin
                        res_re_next = smnr_pkg::sat32(SW'(nim_reg) + SW'(rq));
                    end else begin
                        x_next = rq;
                    end
                end
                smnr_pkg::STEP_II: begin
                    if (fop_reg.term == smnr_pkg::TERM_COR) begin
                        res_im_next = smnr_pkg::sat32(-SW'(nre_reg) - SW'(rq));
                    end else begin
                        c_re_next = smnr_pkg::sat32(SW'(x_reg) - SW'(rq));
                    end
                end
                smnr_pkg::STEP_RI: begin
                    x_next = rq;
                end
                smnr_pkg::STEP_IR: begin
                    c_im_next = smnr_pkg::sat32(-(SW'(x_reg) + SW'(rq)));
                end
                smnr_pkg::STEP_KRE: begin
                    if (fop_reg.term == smnr_pkg::TERM_T1) begin
                        nre_next = nre_reg + AW'(kprod);
                    end else begin
                        r_re_next = kprod;
                    end
                end
                smnr_pkg::STEP_KIM: begin
                    if (fop_reg.term == smnr_pkg::TERM_T1) begin
                        nim_next = nim_reg + AW'(kprod);
                    end else begin
                        r_im_next = kprod;
                    end
                end
                smnr_pkg::STEP_SRE: begin
                    nre_next = nre_reg + AW'(smnr_pkg::sat32(SW'(rq)));
                end
                smnr_pkg::STEP_SIM: begin
                    nim_next = nim_reg + AW'(smnr_pkg::sat32(SW'(rq)));
                end
                default: begin
                    x_next = x_reg;
                end
            endcase
        end
        if (acc_clear) begin
            nre_next = '0;
            nim_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nre_reg <= '0;
            nim_reg <= '0;
        end else begin
            nre_reg <= nre_next;
            nim_reg <= nim_next;
        end
        x_reg      <= x_next;
        c_re_reg   <= c_re_next;
        c_im_reg   <= c_im_next;
        r_re_reg   <= r_re_next;
        r_im_reg   <= r_im_next;
        res_re_reg <= res_re_next;
        res_im_reg <= res_im_next;
    end

    assign res_re = res_re_reg;
    assign res_im = res_im_reg;

endmodule

@@ sv/shell_model_nonlinear_rhs.sv @@
// ============================================================================
// shell_model_nonlinear_rhs
// Shell-model (GOY-type) nonlinear right-hand side with a Coriolis term,
// computed on one shared multiplier under a small sequencer.
// ============================================================================
// Usage: the shells of one velocity field enter in order on the s_ channel,
// each transfer carrying a Q16.16 complex velocity, a Q24.8 wavenumber and a
// final-shell flag. Results leave on the m_ channel, two shells behind the
// input: each ordinary shell yields the result of the shell two places back,
// and the final shell also flushes the last two results, the very last one
// flagged with m_end_of_field. The first two shells of a field give nothing.
// The configuration channel writes the two triad coefficients and the
// rotation rate; writes are accepted every cycle and belong between fields.
// Each result is formed in a check step, 24 multiplications on the single
// 33x33 multiplier, a finishing step and a step that loads the output
// register. s_ready is high only while the sequencer is idle.
// A result waits in the output register while the receiver stalls; the
// sequencer then holds in its emit step until that register is free, and
// s_ready stays low until the last result of the shell has been loaded.
// Reset (synchronous, active low) clears the shell window and the shell
// count, restores the register defaults and drops m_valid.
// ============================================================================
module shell_model_nonlinear_rhs #(
    parameter int VEL_FRAC_BITS = smnr_pkg::VEL_FRAC_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Shell input channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [smnr_pkg::DATA_W-1:0]  s_vel_re,
    input  logic signed [smnr_pkg::DATA_W-1:0]  s_vel_im,
    input  logic        [smnr_pkg::DATA_W-1:0]  s_wavenumber,
    input  logic                                s_final_shell,
    // Result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [smnr_pkg::DATA_W-1:0]  m_rhs_re,
    output logic signed [smnr_pkg::DATA_W-1:0]  m_rhs_im,
    output logic        [smnr_pkg::IDX_W-1:0]   m_shell_index,
    output logic                                m_end_of_field,
    // Configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic        [1:0]                   cfg_index,
    input  logic        [smnr_pkg::DATA_W-1:0]  cfg_data
);

    localparam int DW = smnr_pkg::DATA_W;
    localparam int SEEN_W = smnr_pkg::SEEN_W;
    localparam logic [SEEN_W-1:0] LAST_SHELL = SEEN_W'(smnr_pkg::MAX_SHELLS - 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_RUN   = 4'b0100,
        S_EMIT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic signed [DW-1:0] coef_a2_reg;
    logic signed [DW-1:0] coef_a3_reg;
    logic signed [DW-1:0] rot_reg;

    // Persistent window of the four previous shells; index 0 is the newest.
    logic signed [DW-1:0]     vwin_re_reg [4];
    logic signed [DW-1:0]     vwin_im_reg [4];
    logic        [DW-1:0]     kwin_reg    [4];
    logic        [SEEN_W-1:0] seen_reg;

    // Work buffer for the item in progress: position 2 is always the shell
    // whose result is being formed; it shifts down by one between results.
    logic signed [DW-1:0] w_re_reg [5];
    logic signed [DW-1:0] w_im_reg [5];
    logic        [DW-1:0] w_k_reg  [5];

    logic signed [7:0]  n_reg;
    logic        [1:0]  rem_reg;
    logic               fin_reg;
    smnr_pkg::term_t    term_reg, term_next;
    smnr_pkg::step_t    step_reg, step_next;
    logic               drain_reg, drain_next;

    logic                    m_valid_reg;
    logic signed [DW-1:0]    m_rhs_re_reg;
    logic signed [DW-1:0]    m_rhs_im_reg;
    logic [smnr_pkg::IDX_W-1:0] m_shell_index_reg;
    logic                    m_end_of_field_reg;

    logic              in_xfer;
    logic              cfg_xfer;
    logic [SEEN_W-1:0] s_cap;
    logic              fin_in;
    logic              out_free;
    logic              emit_load;
    logic              do_shift;
    logic              last_step;

    smnr_pkg::uop_t       issue_op;
    logic signed [DW-1:0] a_re, a_im, b_re, b_im, coef;
    logic        [DW-1:0] kval;
    logic signed [DW-1:0] res_re, res_im;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_xfer   = s_valid && s_ready;
    assign cfg_xfer  = cfg_valid && cfg_ready;

    // The shell count is capped so that a field never runs past the last
    // shell; reaching it ends the field as if the final flag were set.
    assign s_cap  = (seen_reg > LAST_SHELL) ? LAST_SHELL : seen_reg;
    assign fin_in = s_final_shell || (s_cap >= LAST_SHELL);

    assign out_free  = !m_valid_reg || m_ready;
    assign emit_load = (state_reg == S_EMIT) && out_free;

    // Moving to the next result: after a skipped negative shell index, or
    // after a result has been handed to the output register.
    assign do_shift = (rem_reg != 2'd0) &&
                      (((state_reg == S_CHECK) && n_reg[7]) || emit_load);

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_a2_reg <= smnr_pkg::COEF_A2_RST;
            coef_a3_reg <= smnr_pkg::COEF_A3_RST;
            rot_reg     <= smnr_pkg::ROTATION_RATE_RST;
        end else if (cfg_xfer) begin
            case (cfg_index)
                smnr_pkg::REG_COEF_A2:       coef_a2_reg <= cfg_data;
                smnr_pkg::REG_COEF_A3:       coef_a3_reg <= cfg_data;
                smnr_pkg::REG_ROTATION_RATE: rot_reg     <= cfg_data;
                default: begin
                    coef_a2_reg <= coef_a2_reg;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Shell window and shell count, updated on each input transfer
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= '0;
            for (int i = 0; i < 4; i++) begin
                vwin_re_reg[i] <= '0;
                vwin_im_reg[i] <= '0;
                kwin_reg[i]    <= '0;
            end
        end else if (in_xfer) begin
            if (fin_in) begin
                seen_reg <= '0;
                for (int i = 0; i < 4; i++) begin
                    vwin_re_reg[i] <= '0;
                    vwin_im_reg[i] <= '0;
                    kwin_reg[i]    <= '0;
                end
            end else begin
                seen_reg       <= s_cap + SEEN_W'(1);
                vwin_re_reg[3] <= vwin_re_reg[2];
                vwin_im_reg[3] <= vwin_im_reg[2];
                kwin_reg[3]    <= kwin_reg[2];
                vwin_re_reg[2] <= vwin_re_reg[1];
                vwin_im_reg[2] <= vwin_im_reg[1];
                kwin_reg[2]    <= kwin_reg[1];
                vwin_re_reg[1] <= vwin_re_reg[0];
                vwin_im_reg[1] <= vwin_im_reg[0];
                kwin_reg[1]    <= kwin_reg[0];
                vwin_re_reg[0] <= s_vel_re;
                vwin_im_reg[0] <= s_vel_im;
                kwin_reg[0]    <= s_wavenumber;
            end
        end
    end

    // ------------------------------------------------------------------
    // Work buffer: loaded from the window plus the new shell, then shifted
    // toward position 0 with zeros entering past the end of the field.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            w_re_reg[0] <= vwin_re_reg[3];
            w_im_reg[0] <= vwin_im_reg[3];
            w_k_reg[0]  <= kwin_reg[3];
            w_re_reg[1] <= vwin_re_reg[2];
            w_im_reg[1] <= vwin_im_reg[2];
            w_k_reg[1]  <= kwin_reg[2];
            w_re_reg[2] <= vwin_re_reg[1];
            w_im_reg[2] <= vwin_im_reg[1];
            w_k_reg[2]  <= kwin_reg[1];
            w_re_reg[3] <= vwin_re_reg[0];
            w_im_reg[3] <= vwin_im_reg[0];
            w_k_reg[3]  <= kwin_reg[0];
            w_re_reg[4] <= s_vel_re;
            w_im_reg[4] <= s_vel_im;
            w_k_reg[4]  <= s_wavenumber;
        end else if (do_shift) begin
            w_re_reg[0] <= w_re_reg[1];
            w_im_reg[0] <= w_im_reg[1];
            w_k_reg[0]  <= w_k_reg[1];
            w_re_reg[1] <= w_re_reg[2];
            w_im_reg[1] <= w_im_reg[2];
            w_k_reg[1]  <= w_k_reg[2];
            w_re_reg[2] <= w_re_reg[3];
            w_im_reg[2] <= w_im_reg[3];
            w_k_reg[2]  <= w_k_reg[3];
            w_re_reg[3] <= w_re_reg[4];
            w_im_reg[3] <= w_im_reg[4];
            w_k_reg[3]  <= w_k_reg[4];
            w_re_reg[4] <= '0;
            w_im_reg[4] <= '0;
            w_k_reg[4]  <= '0;
        end
    end

    // Shell index of the current result and how many results follow it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg   <= '0;
            rem_reg <= '0;
            fin_reg <= 1'b0;
        end else if (in_xfer) begin
            n_reg   <= $signed({1'b0, s_cap}) - 8'sd2;
            rem_reg <= fin_in ? 2'd2 : 2'd0;
            fin_reg <= fin_in;
        end else if (do_shift) begin
            n_reg   <= n_reg + 8'sd1;
            rem_reg <= rem_reg - 2'd1;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer. In the run state one multiplication issues per cycle in
    // the order T1, T2, T3, Coriolis; each finishes in the following cycle,
    // and a step never reads a value finished in the same cycle.
    // ------------------------------------------------------------------
    always_comb begin
        case (term_reg)
            smnr_pkg::TERM_T1:  last_step = (step_reg == smnr_pkg::STEP_KIM);
            smnr_pkg::TERM_T2:  last_step = (step_reg == smnr_pkg::STEP_SIM);
            smnr_pkg::TERM_T3:  last_step = (step_reg == smnr_pkg::STEP_SIM);
            smnr_pkg::TERM_COR: last_step = (step_reg == smnr_pkg::STEP_II);
            default:            last_step = 1'b1;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        term_next  = term_reg;
        step_next  = step_reg;
        drain_next = drain_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_xfer) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                term_next  = smnr_pkg::TERM_T1;
                step_next  = smnr_pkg::STEP_RR;
                drain_next = 1'b0;
                if (!n_reg[7]) begin
                    state_next = S_RUN;
                end else if (rem_reg == 2'd0) begin
                    state_next = S_IDLE;
                end
            end
            S_RUN: begin
                if (drain_reg) begin
                    state_next = S_EMIT;
                end else if (last_step) begin
                    if (term_reg == smnr_pkg::TERM_COR) begin
                        drain_next = 1'b1;
                    end else begin
                        term_next = smnr_pkg::term_t'(term_reg + 2'd1);
                        step_next = smnr_pkg::STEP_RR;
                    end
                end else begin
                    step_next = smnr_pkg::step_t'(step_reg + 3'd1);
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    state_next = (rem_reg == 2'd0) ? S_IDLE : S_CHECK;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            term_reg  <= smnr_pkg::TERM_T1;
            step_reg  <= smnr_pkg::STEP_RR;
            drain_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            term_reg  <= term_next;
            step_reg  <= step_next;
            drain_reg <= drain_next;
        end
    end

    // Triad operands for the current term, taken from fixed buffer places:
    // T1 uses shells n+2, n+1 and k_n; T2 uses n+1, n-1 and k_{n-1};
    // T3 uses n-1, n-2 and k_{n-2}.
    always_comb begin
        a_re = w_re_reg[4];
        a_im = w_im_reg[4];
        b_re = w_re_reg[3];
        b_im = w_im_reg[3];
        kval = w_k_reg[2];
        case (term_reg)
            smnr_pkg::TERM_T2: begin
                a_re = w_re_reg[3];
                a_im = w_im_reg[3];
                b_re = w_re_reg[1];
                b_im = w_im_reg[1];
                kval = w_k_reg[1];
            end
            smnr_pkg::TERM_T3: begin
                a_re = w_re_reg[1];
                a_im = w_im_reg[1];
                b_re = w_re_reg[0];
                b_im = w_im_reg[0];
                kval = w_k_reg[0];
            end
            default: begin
                kval = w_k_reg[2];
            end
        endcase
    end

    assign coef = (term_reg == smnr_pkg::TERM_T2) ? coef_a2_reg : coef_a3_reg;

    assign issue_op.valid = (state_reg == S_RUN) && !drain_reg;
    assign issue_op.term  = term_reg;
    assign issue_op.step  = step_reg;

    smnr_datapath #(
        .VEL_FRAC_BITS (VEL_FRAC_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .issue_op  (issue_op),
        .acc_clear (state_reg == S_CHECK),
        .a_re      (a_re),
        .a_im      (a_im),
        .b_re      (b_re),
        .b_im      (b_im),
        .kval      (kval),
        .coef      (coef),
        .omega     (rot_reg),
        .ctr_re    (w_re_reg[2]),
        .ctr_im    (w_im_reg[2]),
        .res_re    (res_re),
        .res_im    (res_im)
    );

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (emit_load) begin
            m_rhs_re_reg       <= res_re;
            m_rhs_im_reg       <= res_im;
            m_shell_index_reg  <= n_reg[smnr_pkg::IDX_W-1:0];
            m_end_of_field_reg <= fin_reg && (rem_reg == 2'd0);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_rhs_re       = m_rhs_re_reg;
    assign m_rhs_im       = m_rhs_im_reg;
    assign m_shell_index  = m_shell_index_reg;
    assign m_end_of_field = m_end_of_field_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_final_clears_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && s_final_shell) |=> (seen_reg == '0))
        else $error("shell count not cleared after the final shell");

    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (seen_reg <= LAST_SHELL))
        else $error("shell count beyond the last shell");

    a_emit_index_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT) |-> !n_reg[7])
        else $error("result formed for a shell outside the field");

    a_drain_to_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_RUN) && drain_reg) |=> (state_reg == S_EMIT))
        else $error("sequencer did not hand over the finished result");

    a_end_flag_only_final: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_load |=> (!m_end_of_field || $past(fin_reg)))
        else $error("end of field flagged on an ordinary shell");

endmodule
